// ===== hdl/bmvg_pkg.sv =====
// Shared types and constants for the barcode mismatch variant generator.
package bmvg_pkg;

    localparam int BASE_BITS     = 3;
    localparam int BASE_VARIANTS = 5;
    localparam int MAX_BASES     = 21;
    localparam int NUM_COMP      = 4;
    localparam int NUM_LEVELS    = 2 * NUM_COMP;
    localparam int IDX_W         = 32;
    localparam int KMER_W        = 63;
    localparam int LEN_W         = 5;
    localparam int DIV_W         = 8;
    localparam int OFF_W         = 7;
    localparam int POS_W         = 7;
    localparam int SHIFT_W       = 6;
    localparam int CNT_W         = 4;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 8;
    localparam int CHUNK         = 8;
    localparam int CHUNKS        = IDX_W / CHUNK;
    localparam int DIV_STAGES    = NUM_LEVELS * CHUNKS;
    localparam int APPLY_STAGES  = NUM_COMP;
    localparam int NUM_STAGES    = 1 + DIV_STAGES + APPLY_STAGES;

    localparam logic [CFG_IDX_W-1:0] REG_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEN0  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEN1  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEN2  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEN3  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MODES = 3'd5;

    localparam logic [1:0] MODE_ONE = 2'd1;
    localparam logic [1:0] MODE_TWO = 2'd2;

    // Per-level divisors and flags; level 2k is the low digit of component
    // NUM_COMP-1-k, level 2k+1 its high digit.
    typedef struct packed {
        logic [NUM_LEVELS-1:0][DIV_W-1:0] divisor;
        logic [NUM_LEVELS-1:0]            active;
        logic [NUM_COMP-1:0][OFF_W-1:0]   offset;
    } bmvg_cfg_t;

    typedef struct packed {
        logic                             valid;
        logic [KMER_W-1:0]                kmer;
        logic [IDX_W-1:0]                 idx;
        logic [DIV_W-1:0]                 rem;
        logic [NUM_LEVELS-1:0][DIV_W-1:0] digit;
        logic [CNT_W-1:0]                 cnt;
    } bmvg_stage_t;

endpackage

// ===== hdl/bmvg_cfg.sv =====
// Configuration registers and the per-level divisor and offset table.
module bmvg_cfg import bmvg_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output bmvg_cfg_t             cfg
);

    logic [2:0]                       count_reg;
    logic [NUM_COMP-1:0][LEN_W-1:0]   len_reg;
    logic [2*NUM_COMP-1:0]            modes_reg;
    bmvg_cfg_t                        cfg_reg, cfg_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 3'd1;
            len_reg   <= {LEN_W'(0), LEN_W'(0), LEN_W'(0), LEN_W'(8)};
            modes_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_COUNT: count_reg  <= cfg_wdata[2:0];
                REG_LEN0:  len_reg[0] <= cfg_wdata[LEN_W-1:0];
                REG_LEN1:  len_reg[1] <= cfg_wdata[LEN_W-1:0];
                REG_LEN2:  len_reg[2] <= cfg_wdata[LEN_W-1:0];
                REG_LEN3:  len_reg[3] <= cfg_wdata[LEN_W-1:0];
                REG_MODES: modes_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [2:0]       n;
        logic [1:0]       mode;
        logic             en;
        logic [DIV_W-1:0] r1;
        logic [OFF_W-1:0] acc;
        n   = (count_reg > 3'(NUM_COMP)) ? 3'(NUM_COMP) : count_reg;
        acc = '0;
        cfg_next = '0;
        for (int c = NUM_COMP - 1; c >= 0; c--) begin
            mode = modes_reg[2*c +: 2];
            en   = (3'(c) < n) && (len_reg[c] != '0) &&
                   ((mode == MODE_ONE) || (mode == MODE_TWO));
            r1   = DIV_W'(len_reg[c]) * DIV_W'(BASE_VARIANTS);
            cfg_next.active[2*(NUM_COMP-1-c)]    = en;
            cfg_next.divisor[2*(NUM_COMP-1-c)]   = en ? r1 : DIV_W'(1);
            cfg_next.active[2*(NUM_COMP-1-c)+1]  = en && (mode == MODE_TWO);
            cfg_next.divisor[2*(NUM_COMP-1-c)+1] =
                (en && (mode == MODE_TWO)) ? r1 : DIV_W'(1);
            cfg_next.offset[c] = acc;
            if (3'(c) < n) acc = acc + OFF_W'(len_reg[c]);
        end
    end

    always_ff @(posedge aclk) begin
        cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/barcode_mismatch_variant_generator_core.sv =====
// Top level: pipelined mismatch variant generator for packed barcodes.
// Pipeline: 37 register stages (one input stage, 32 radix-decode stages of 8 quotient bits each,
// 4 substitution stages).
// Throughput: one transaction per cycle; a stage holds only while it is full and the next one holds.
// Reset: synchronous active-low aresetn empties the pipeline and restores the
// configuration defaults (one component of eight bases, no mismatches).
module barcode_mismatch_variant_generator_core import bmvg_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [KMER_W-1:0]     s_original_kmer,
    input  logic [IDX_W-1:0]      s_variant_index,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [KMER_W-1:0]     m_variant_kmer,
    output logic [CNT_W-1:0]      m_mismatch_count
);

    bmvg_cfg_t   cfg;
    bmvg_stage_t st_reg  [NUM_STAGES];
    bmvg_stage_t st_next [NUM_STAGES];
    logic [NUM_STAGES-1:0] free;

    bmvg_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // A stage may load when it is empty or its contents move on this cycle.
    assign free[NUM_STAGES-1] = !st_reg[NUM_STAGES-1].valid || m_ready;
    genvar g;
    generate
        for (g = 0; g < NUM_STAGES - 1; g++) begin : g_free
            assign free[g] = !st_reg[g].valid || free[g+1];
        end
    endgenerate

    assign s_ready = free[0];

    // Input stage: capture the transaction.
    always_comb begin
        st_next[0]       = '0;
        st_next[0].valid = s_valid;
        st_next[0].kmer  = s_original_kmer;
        st_next[0].idx   = s_variant_index;
    end

    generate
        for (g = 1; g < NUM_STAGES; g++) begin : g_stage
            if (g <= DIV_STAGES) begin : g_div
                // Restoring division by the level radix, 8 quotient bits per stage;
                // the quotient replaces the index bits in place.
                localparam int L  = (g - 1) / CHUNKS;
                localparam int CH = (g - 1) % CHUNKS;
                always_comb begin
                    logic [DIV_W:0]   r;
                    logic [DIV_W-1:0] dv;
                    st_next[g] = st_reg[g-1];
                    dv = cfg.divisor[L];
                    if (CH == 0) st_next[g].rem = '0;
                    for (int b = 0; b < CHUNK; b++) begin
                        r = {st_next[g].rem, st_next[g].idx[IDX_W-1-CH*CHUNK-b]};
                        if (r >= {1'b0, dv}) begin
                            r = r - {1'b0, dv};
                            st_next[g].idx[IDX_W-1-CH*CHUNK-b] = 1'b1;
                        end else begin
                            st_next[g].idx[IDX_W-1-CH*CHUNK-b] = 1'b0;
                        end
                        st_next[g].rem = r[DIV_W-1:0];
                    end
                    if (CH == CHUNKS - 1) st_next[g].digit[L] = st_next[g].rem;
                end
            end else begin : g_apply
                // One component per stage: high digit first, then low digit.
                // Split the digit into position and base by multiplying by 205/1024,
                // exact for every 8-bit digit.
                localparam int P = g - 1 - DIV_STAGES;
                localparam int C = NUM_COMP - 1 - P;
                always_comb begin
                    logic [DIV_W-1:0]     d;
                    logic [15:0]          prod;
                    logic [DIV_W-1:0]     q;
                    logic [POS_W-1:0]     pos;
                    logic [BASE_BITS-1:0] base;
                    logic [BASE_BITS-1:0] old;
                    logic [SHIFT_W-1:0]   sh;
                    logic [2:0]           j;
                    st_next[g] = st_reg[g-1];
                    for (int a = 0; a < 2; a++) begin
                        j    = (a == 0) ? 3'(2*P + 1) : 3'(2*P);
                        d    = st_next[g].digit[j];
                        prod = 16'(d) * 16'd205;
                        q    = DIV_W'(prod[15:10]);
                        pos  = POS_W'(cfg.offset[C]) + POS_W'(q);
                        base = BASE_BITS'(d - q * DIV_W'(BASE_VARIANTS));
                        sh   = SHIFT_W'(pos * POS_W'(BASE_BITS));
                        old  = st_next[g].kmer[sh +: BASE_BITS];
                        if (cfg.active[j] && (pos < POS_W'(MAX_BASES))) begin
                            st_next[g].kmer[sh +: BASE_BITS] = base;
                            if (old != base) st_next[g].cnt = st_next[g].cnt + CNT_W'(1);
                        end
                    end
                end
            end
        end
    endgenerate

    // Advance each stage when it may load; hold otherwise.
    generate
        for (g = 0; g < NUM_STAGES; g++) begin : g_reg
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    st_reg[g].valid <= 1'b0;
                end else if (free[g]) begin
                    st_reg[g].valid <= st_next[g].valid;
                end
                if (free[g]) begin
                    st_reg[g].kmer  <= st_next[g].kmer;
                    st_reg[g].idx   <= st_next[g].idx;
                    st_reg[g].rem   <= st_next[g].rem;
                    st_reg[g].digit <= st_next[g].digit;
                    st_reg[g].cnt   <= st_next[g].cnt;
                end
            end
        end
    endgenerate

    assign m_valid          = st_reg[NUM_STAGES-1].valid;
    assign m_variant_kmer   = st_reg[NUM_STAGES-1].kmer;
    assign m_mismatch_count = st_reg[NUM_STAGES-1].cnt;

    // An empty input stage must always take a transaction.
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !st_reg[0].valid |-> s_ready)
        else $error("input stage empty but not ready");

    // At most one change per substitution level.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_mismatch_count <= CNT_W'(NUM_LEVELS)))
        else $error("mismatch count exceeds level count");

    // A held result must not be overwritten.
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_mismatch_count)))
        else $error("stalled result changed");

endmodule
